>>> hw/rtl/temperature_alarm_escalation_defines.svh
// assertion macros shared by the temperature alarm escalation rtl
`ifndef TEMPERATURE_ALARM_ESCALATION_DEFINES_SVH
`define TEMPERATURE_ALARM_ESCALATION_DEFINES_SVH

// antecedent and consequent in the same cycle
`define TAE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the cycle after the antecedent
`define TAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/tae_pkg.sv
// types, codes and constants of the temperature alarm escalation block
`default_nettype none

package tae_pkg;

   // sensor scaling: adc*3300 > (threshold*10 + 500)*4096
   localparam int unsigned AdcFullScaleMv = 3300;
   localparam int unsigned MvPerDegree    = 10;
   localparam int unsigned MvOffset       = 500;
   localparam int unsigned AdcShift       = 12;
   localparam int unsigned ProductWidth   = 24;

   localparam logic [5:0] THRESHOLD_RESET      = 6'd28;
   localparam logic [5:0] THRESHOLD_MIN_RESET  = 6'd15;
   localparam logic [5:0] THRESHOLD_MAX_RESET  = 6'd35;
   localparam logic [3:0] SLOW_STEPS_RESET     = 4'd5;
   localparam logic [3:0] FAST_STEPS_RESET     = 4'd5;

   // register indexes
   localparam logic [1:0] CSR_THRESHOLD_MIN = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD_MAX = 2'd1;
   localparam logic [1:0] CSR_SLOW_STEPS    = 2'd2;
   localparam logic [1:0] CSR_FAST_STEPS    = 2'd3;

   // mode codes on the result channel
   localparam logic [2:0] MODE_CODE_SETUP = 3'd0;
   localparam logic [2:0] MODE_CODE_ARMED = 3'd1;
   localparam logic [2:0] MODE_CODE_SLOW  = 3'd2;
   localparam logic [2:0] MODE_CODE_FAST  = 3'd3;
   localparam logic [2:0] MODE_CODE_RELAY = 3'd4;

   localparam logic [1:0] BLINK_OFF  = 2'd0;
   localparam logic [1:0] BLINK_SLOW = 2'd1;
   localparam logic [1:0] BLINK_FAST = 2'd2;

   typedef enum logic [4:0] {
      MODE_SETUP = 5'b00001,
      MODE_ARMED = 5'b00010,
      MODE_SLOW  = 5'b00100,
      MODE_FAST  = 5'b01000,
      MODE_RELAY = 5'b10000
   } mode_type;

   typedef struct packed {
      logic        up_button_n;
      logic        down_button_n;
      logic        clear_button_n;
      logic        arm_button_n;
      logic [11:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic [2:0] mode_after;
      logic [5:0] threshold_now;
      logic [1:0] blink_rate;
      logic       relay_pulse;
      logic       over_threshold;
   } rsp_type;

   typedef struct packed {
      logic [5:0] threshold_min;
      logic [5:0] threshold_max;
      logic [3:0] slow_alarm_steps;
      logic [3:0] fast_alarm_steps;
   } cfg_type;

   typedef struct packed {
      mode_type   mode;
      logic [5:0] threshold;
      logic [4:0] alarm_steps;
   } state_type;

   function automatic logic [2:0] mode_code(input mode_type mode);
      logic [2:0] code;
      unique case (mode)
         MODE_ARMED: code = MODE_CODE_ARMED;
         MODE_SLOW:  code = MODE_CODE_SLOW;
         MODE_FAST:  code = MODE_CODE_FAST;
         MODE_RELAY: code = MODE_CODE_RELAY;
         default:    code = MODE_CODE_SETUP;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tae_csr.sv
// configuration registers: threshold limits and alarm stage lengths
`default_nettype none

module tae_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_wdata,
   output tae_pkg::cfg_type cfg
);
   import tae_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD_MIN: cfg_in.threshold_min    = csr_wdata;
            CSR_THRESHOLD_MAX: cfg_in.threshold_max    = csr_wdata;
            CSR_SLOW_STEPS:    cfg_in.slow_alarm_steps = csr_wdata[3:0];
            CSR_FAST_STEPS:    cfg_in.fast_alarm_steps = csr_wdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_min    <= THRESHOLD_MIN_RESET;
         cfg_ff.threshold_max    <= THRESHOLD_MAX_RESET;
         cfg_ff.slow_alarm_steps <= SLOW_STEPS_RESET;
         cfg_ff.fast_alarm_steps <= FAST_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/tae_step.sv
// one supervision step: threshold setup, over-temperature check, escalation
`default_nettype none

module tae_step (
   input  logic               clock,
   input  tae_pkg::state_type state,
   input  tae_pkg::cfg_type   cfg,
   input  tae_pkg::req_type   req,
   output tae_pkg::state_type state_next,
   output tae_pkg::rsp_type   rsp
);
   import tae_pkg::*;

   logic                    up;
   logic                    down;
   logic                    clear;
   logic                    arm;
   logic [ProductWidth-1:0] sample_mv;
   logic [10:0]             limit_mv;
   logic [ProductWidth-1:0] limit_scaled;
   logic                    hot;
   logic [4:0]              steps_inc;
   logic [1:0]              blink;
   logic                    relay;
   logic                    over;

   assign up    = ~req.up_button_n;
   assign down  = ~req.down_button_n;
   assign clear = ~req.clear_button_n;
   assign arm   = ~req.arm_button_n;

   // exact integer form of the millivolt compare
   assign sample_mv    = ProductWidth'(req.adc_sample) * ProductWidth'(AdcFullScaleMv);
   assign limit_mv     = 11'(state.threshold) * 11'(MvPerDegree) + 11'(MvOffset);
   assign limit_scaled = ProductWidth'(limit_mv) << AdcShift;
   assign hot          = sample_mv > limit_scaled;

   assign steps_inc = state.alarm_steps + 5'd1;

   always_comb begin
      state_next = state;
      blink      = BLINK_OFF;
      relay      = 1'b0;
      over       = 1'b0;
      unique case (state.mode)
         MODE_ARMED: begin
            if (hot) begin
               over                   = 1'b1;
               state_next.mode        = MODE_SLOW;
               state_next.alarm_steps = 5'd0;
            end
         end
         MODE_SLOW: begin
            blink                  = BLINK_SLOW;
            state_next.alarm_steps = steps_inc;
            if (steps_inc >= {1'b0, cfg.slow_alarm_steps}) begin
               state_next.mode        = MODE_FAST;
               state_next.alarm_steps = 5'd0;
            end
         end
         MODE_FAST: begin
            blink                  = BLINK_FAST;
            state_next.alarm_steps = steps_inc;
            if (steps_inc >= {1'b0, cfg.fast_alarm_steps}) begin
               state_next.mode        = MODE_RELAY;
               state_next.alarm_steps = 5'd0;
            end
         end
         MODE_RELAY: begin
            blink = BLINK_FAST;
            relay = 1'b1;
         end
         default: begin
            // setup, and any broken mode pattern behaves as setup
            state_next.mode = MODE_SETUP;
            priority if (up && state.threshold < cfg.threshold_max) begin
               state_next.threshold = state.threshold + 6'd1;
            end else if (down && state.threshold > cfg.threshold_min) begin
               state_next.threshold = state.threshold - 6'd1;
            end else if (arm) begin
               state_next.mode = MODE_ARMED;
            end else begin
               state_next.threshold = state.threshold;
            end
         end
      endcase
      // clear wins over the mode and step count updates in the step
      if (clear) begin
         state_next.mode        = MODE_SETUP;
         state_next.alarm_steps = 5'd0;
      end
   end

   assign rsp.mode_after     = mode_code(state_next.mode);
   assign rsp.threshold_now  = state_next.threshold;
   assign rsp.blink_rate     = blink;
   assign rsp.relay_pulse    = relay;
   assign rsp.over_threshold = over;

   `include "temperature_alarm_escalation_defines.svh"

   `TAE_ASSERT_SAME(a_relay_blinks_fast, clock, 1'b0, relay, blink == BLINK_FAST, "relay without fast blink")
   `TAE_ASSERT_SAME(a_over_only_armed, clock, 1'b0, over, state.mode == MODE_ARMED && state_next.mode != MODE_ARMED, "over flag outside armed mode")
   `TAE_ASSERT_SAME(a_clear_to_setup, clock, 1'b0, clear, state_next.mode == MODE_SETUP && state_next.alarm_steps == 5'd0, "clear did not return to setup")

endmodule

`default_nettype wire

>>> hw/rtl/temperature_alarm_escalation.sv
// top level of the temperature alarm escalation block
//
//   port group   direction   payload           handshake
//   req_         in          tae_pkg::req_type  req_valid / req_stall
//   rsp_         out         tae_pkg::rsp_type  rsp_valid / rsp_stall
//   csr_         in          6-bit write data   csr_write, csr_index
//
// one request per cycle sustained while rsp_stall is low; a request taken
// into the input register moves through the step logic into the result
// register, from which its result is offered on rsp_data
// the mode, threshold and step count update as a request moves into the
// result register; reset puts setup mode, threshold 28 and default registers
// a stalled result holds and the input register still takes one more request
`default_nettype none

module temperature_alarm_escalation (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tae_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tae_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_wdata
);
   import tae_pkg::*;

   cfg_type   cfg;
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   state_type state_ff;
   state_type state_next;
   rsp_type   step_rsp;
   logic      advance;
   logic      accept;

   tae_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tae_step u_step (
      .clock      (clock),
      .state      (state_ff),
      .cfg        (cfg),
      .req        (in_data_ff),
      .state_next (state_next),
      .rsp        (step_rsp)
   );

   // request moves on when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.mode        <= MODE_SETUP;
         state_ff.threshold   <= THRESHOLD_RESET;
         state_ff.alarm_steps <= 5'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `include "temperature_alarm_escalation_defines.svh"

   `TAE_ASSERT_NEXT(a_advance_fills_output, clock, reset, advance, out_valid_ff, "result register not loaded")
   `TAE_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall, "request stalled without a full pipe")
   `TAE_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(state_ff), "state changed without a request")
   `TAE_ASSERT_SAME(a_steps_bounded, clock, reset, 1'b1, state_ff.alarm_steps < 5'd16, "alarm step count out of range")

endmodule

`default_nettype wire
